>>> hw/rtl/brun_pkg.sv
// Shared types and constants of the bitmap run allocator.
// Holds request and status codes, item structs and the controller states.
// No dependencies.
package brun_pkg;

	// Default map depth in bytes and reset value of the map size register
	localparam int MAP_BYTES_MAX_DEF = 128;
	localparam logic [7:0] MAP_BYTES_RST = 8'd128;

	typedef enum logic [1:0] {
		REQ_TEST  = 2'd0,
		REQ_WRITE = 2'd1,
		REQ_SCAN  = 2'd2,
		REQ_CLEAR = 2'd3
	} req_type_t;

	typedef enum logic [1:0] {
		STS_OK    = 2'd0,
		STS_RANGE = 2'd1,
		STS_NOFIT = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [9:0]  bit_index;
		logic        bit_value;
		logic [10:0] run_length;
	} in_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [9:0] start_index;
		logic       bit_read;
	} out_item_t;

	// Result of scanning one map byte for a free run
	typedef struct packed {
		logic        found;
		logic [2:0]  pos;
		logic [10:0] run_out;
	} scan_res_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_RMW,
		ST_SCAN,
		ST_CLEAR,
		ST_DONE
	} brun_state_t;

endpackage

>>> hw/rtl/bitmap_run_allocator_core.sv
// First-fit bitmap run allocator: test, write, clear and free-run scan of a usage map.
// A range error goes straight to the result; test and write read the addressed byte and a
// write stores it back changed; clear sweeps the map bytes in use; a scan reads one map byte
// per cycle (set by the single read port of the map memory). One item is in work at a time.
// After reset the map is swept to zero, with in_stall high until the sweep ends.
// Depends on brun_pkg, brun_map_mem and brun_byte_scan.
module bitmap_run_allocator_core import brun_pkg::*; #(
	parameter int MAP_BYTES_MAX = MAP_BYTES_MAX_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  in_item_t   in_item,
	output logic       out_valid,
	input  logic       out_stall,
	output out_item_t  out_item
);

	localparam int AW  = (MAP_BYTES_MAX > 1) ? $clog2(MAP_BYTES_MAX) : 1;
	localparam int NBW = ($clog2(MAP_BYTES_MAX + 1) > 8) ? $clog2(MAP_BYTES_MAX + 1) : 8;
	localparam int CW  = NBW + 3;
	localparam int IW  = (AW > 7) ? AW : 7;
	localparam logic [NBW-1:0] NB_MAX = NBW'(MAP_BYTES_MAX);

	brun_state_t state_q, state_d;

	logic [7:0]     map_bytes_q;
	logic [NBW-1:0] nb;
	logic [CW-1:0]  nunits;
	logic [NBW-1:0] cnt_q;
	in_item_t       req_q;
	logic [AW-1:0]  addr_q;
	logic [10:0]    run_q;
	logic           valid_s1;
	logic           last_s1;
	logic [NBW-1:0] byte_s1;
	out_item_t      res_q;
	out_item_t      out_q;
	logic           out_valid_q;

	logic           in_acc;
	logic           out_free;
	logic           idx_bad;
	logic           len_bad;
	logic           req_bad;
	logic [IW-1:0]  in_byte;
	logic           scan_issue;
	logic           scan_end;
	logic           init_last;
	logic           clear_last;

	logic           rd_en;
	logic [AW-1:0]  rd_addr;
	logic [7:0]     rd_data;
	logic           wr_en;
	logic [AW-1:0]  wr_addr;
	logic [7:0]     wr_data;
	logic [7:0]     bit_mask;
	scan_res_t      scan;

	// Map size in use, clamped to one byte at least and to the memory depth
	always_comb begin
		logic [NBW-1:0] mb;
		mb = NBW'(map_bytes_q);
		if (mb == '0) begin
			nb = NBW'(1);
		end else if (mb > NB_MAX) begin
			nb = NB_MAX;
		end else begin
			nb = mb;
		end
	end
	assign nunits = {nb, 3'b000};

	assign in_acc     = in_valid && !in_stall;
	assign out_free   = !out_valid_q || !out_stall;
	assign idx_bad    = CW'(in_item.bit_index) >= nunits;
	assign len_bad    = (in_item.run_length == '0) || (CW'(in_item.run_length) > nunits);
	assign req_bad    = (((in_item.req_type == REQ_TEST) || (in_item.req_type == REQ_WRITE))
		&& idx_bad) || ((in_item.req_type == REQ_SCAN) && len_bad);
	assign in_byte    = IW'(in_item.bit_index[9:3]);
	assign scan_issue = (state_q == ST_SCAN) && (cnt_q != nb);
	assign scan_end   = valid_s1 && (scan.found || last_s1);
	assign init_last  = cnt_q == NB_MAX - NBW'(1);
	assign clear_last = cnt_q == nb - NBW'(1);
	assign bit_mask   = 8'(1) << req_q.bit_index[2:0];

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_INIT: begin
				if (init_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_acc) begin
					unique case (in_item.req_type)
						REQ_TEST, REQ_WRITE: state_d = idx_bad ? ST_DONE : ST_RMW;
						REQ_SCAN:            state_d = len_bad ? ST_DONE : ST_SCAN;
						REQ_CLEAR:           state_d = ST_CLEAR;
						default:             state_d = ST_DONE;
					endcase
				end
			end
			ST_RMW: state_d = ST_DONE;
			ST_SCAN: begin
				if (scan_end) begin
					state_d = ST_DONE;
				end
			end
			ST_CLEAR: begin
				if (clear_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_INIT;
		endcase
	end

	// Memory control per state
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		unique case (state_q)
			ST_INIT, ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = cnt_q[AW-1:0];
			end
			ST_IDLE: begin
				rd_en   = in_acc;
				rd_addr = in_byte[AW-1:0];
			end
			ST_RMW: begin
				wr_en   = req_q.req_type == REQ_WRITE;
				wr_addr = addr_q;
				wr_data = req_q.bit_value ? (rd_data | bit_mask) : (rd_data & ~bit_mask);
			end
			ST_SCAN: begin
				rd_en   = scan_issue;
				rd_addr = cnt_q[AW-1:0];
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	// Hold the state and the map size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			map_bytes_q <= MAP_BYTES_RST;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				map_bytes_q <= cfg_wr_data;
			end
		end
	end

	// Sweep counter, also the scan read address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= scan_issue;
			if (state_q == ST_IDLE) begin
				cnt_q <= '0;
			end else if (state_q == ST_INIT || state_q == ST_CLEAR || scan_issue) begin
				cnt_q <= cnt_q + NBW'(1);
			end
		end
	end

	// Latch the request, track the scan run
	always_ff @(posedge clk) begin
		if (in_acc) begin
			req_q  <= in_item;
			addr_q <= in_byte[AW-1:0];
			run_q  <= '0;
		end else if (valid_s1) begin
			run_q <= scan.run_out;
		end
		last_s1 <= cnt_q == nb - NBW'(1);
		byte_s1 <= cnt_q;
	end

	// Form the result of the item in work
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_acc) begin
			res_q.status      <= req_bad ? STS_RANGE : STS_OK;
			res_q.start_index <= '0;
			res_q.bit_read    <= 1'b0;
		end else if (state_q == ST_RMW) begin
			if (req_q.req_type == REQ_TEST) begin
				res_q.bit_read <= rd_data[req_q.bit_index[2:0]];
			end
		end else if (state_q == ST_SCAN && scan_end) begin
			if (scan.found) begin
				res_q.start_index <= {byte_s1[6:0], scan.pos} + 10'd1 - req_q.run_length[9:0];
			end else begin
				res_q.status <= STS_NOFIT;
			end
		end
	end

	// Output register: load on finish, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_q <= res_q;
		end
	end

	assign in_stall  = state_q != ST_IDLE;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	brun_map_mem #(
		.DEPTH (MAP_BYTES_MAX),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	brun_byte_scan u_scan (
		.map_byte (rd_data),
		.run_in   (run_q),
		.run_len  (req_q.run_length),
		.res      (scan)
	);

endmodule

>>> hw/rtl/brun_map_mem.sv
// Usage map storage: one write port, one read port with registered data.
// Depends on nothing; sized by parameters from the top level.
module brun_map_mem #(
	parameter int DEPTH = 128,
	parameter int AW    = 7
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data
);

	logic [7:0] mem [DEPTH];

	// Write the addressed byte
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read of the addressed byte
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> hw/rtl/brun_byte_scan.sv
// Free-run counter over one map byte, lowest bit first.
// Depends on brun_pkg for the scan result struct.
module brun_byte_scan import brun_pkg::*; (
	input  logic [7:0]  map_byte,
	input  logic [10:0] run_in,
	input  logic [10:0] run_len,
	output scan_res_t   res
);

	// Extend or reset the run at each unit, note the first unit where it fits
	always_comb begin
		logic [10:0] run;
		logic        found;
		logic [2:0]  pos;
		run   = run_in;
		found = 1'b0;
		pos   = 3'd0;
		for (int k = 0; k < 8; k++) begin
			if (map_byte[k]) begin
				run = '0;
			end else begin
				run = run + 11'd1;
			end
			if (!found && run == run_len) begin
				found = 1'b1;
				pos   = 3'(k);
			end
		end
		res.found   = found;
		res.pos     = pos;
		res.run_out = run;
	end

endmodule

>>> test/tb_bitmap_run_allocator_core.sv
// Testbench for bitmap_run_allocator_core: bit test, bit write, map clear and free-run scan.
// Predicts every result from a shadow copy of the usage map and the map size register.
// Depends on brun_pkg and the bitmap_run_allocator_core RTL.
`timescale 1ns / 1ps

module tb_bitmap_run_allocator_core;
	import brun_pkg::*;

	localparam int MAP_DEPTH   = MAP_BYTES_MAX_DEF;
	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int ITEMS_PER_PHASE = 216;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      cfg_wr_en;
	logic [7:0] cfg_wr_data;
	logic      in_valid;
	logic      in_stall;
	in_item_t  in_item;
	logic      out_valid;
	logic      out_stall;
	out_item_t out_item;

	// Shadow state of the allocator
	logic [7:0] unit_map [MAP_DEPTH];
	logic [7:0] map_size_cfg;

	out_item_t pending_results [$];
	int        error_count = 0;
	int        cycle_count = 0;
	int        send_idle_pct = 0;
	int        recv_idle_pct = 0;

	bitmap_run_allocator_core #(
		.MAP_BYTES_MAX(MAP_DEPTH)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_item    (in_item),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_item   (out_item)
	);

	// Clock: 8 ns period
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("** bitmap_run_allocator_core: FAILED **");
			$finish;
		end
	end

	// Map size as the block uses it: zero acts as one, oversize clamps to the depth
	function automatic int eff_map_bytes();
		if (map_size_cfg == 8'd0)
			return 1;
		if (map_size_cfg > MAP_DEPTH)
			return MAP_DEPTH;
		return int'(map_size_cfg);
	endfunction

	// Compute the result of one request and update the shadow map
	function automatic out_item_t allocator_predict(input in_item_t it);
		out_item_t res;
		int        nbytes;
		int        units;
		int        run;
		int        u;
		bit        found;
		nbytes = eff_map_bytes();
		units  = nbytes * 8;
		res    = '0;
		run    = 0;
		found  = 1'b0;
		case (req_type_t'(it.req_type))
			REQ_TEST: begin
				if (int'(it.bit_index) >= units)
					res.status = STS_RANGE;
				else
					res.bit_read = unit_map[it.bit_index[9:3]][it.bit_index[2:0]];
			end
			REQ_WRITE: begin
				if (int'(it.bit_index) >= units)
					res.status = STS_RANGE;
				else
					unit_map[it.bit_index[9:3]][it.bit_index[2:0]] = it.bit_value;
			end
			REQ_SCAN: begin
				if (it.run_length == 11'd0 || int'(it.run_length) > units) begin
					res.status = STS_RANGE;
				end else begin
					// first fit: lowest start of a long enough free run
					for (u = 0; u < units && !found; u++) begin
						if (unit_map[u >> 3][u & 7])
							run = 0;
						else
							run++;
						if (run == int'(it.run_length)) begin
							found = 1'b1;
							res.start_index = 10'(u + 1 - run);
						end
					end
					if (!found)
						res.status = STS_NOFIT;
				end
			end
			default: begin
				// clear only the bytes in use
				for (u = 0; u < nbytes; u++)
					unit_map[u] = 8'h00;
			end
		endcase
		return res;
	endfunction

	function automatic in_item_t make_req(input req_type_t kind, input int idx, input bit val,
			input int len);
		in_item_t it;
		it.req_type   = kind;
		it.bit_index  = 10'(idx);
		it.bit_value  = val;
		it.run_length = 11'(len);
		return it;
	endfunction

	// Random request, mostly in range for the current map size
	function automatic in_item_t random_req();
		in_item_t it;
		int       units;
		int       pick;
		int       len_pick;
		int       short_max;
		units     = eff_map_bytes() * 8;
		short_max = (units < 12) ? units : 12;
		pick      = $urandom_range(99);
		len_pick  = $urandom_range(19);
		if (pick < 3)
			it.req_type = REQ_CLEAR;
		else if (pick < 45)
			it.req_type = REQ_WRITE;
		else if (pick < 68)
			it.req_type = REQ_TEST;
		else
			it.req_type = REQ_SCAN;
		if ($urandom_range(9) == 0)
			it.bit_index = 10'($urandom);
		else
			it.bit_index = 10'($urandom_range(units - 1));
		it.bit_value = ($urandom_range(99) < 35);
		if (len_pick == 0)
			it.run_length = 11'd0;
		else if (len_pick == 1)
			it.run_length = 11'($urandom);
		else if (len_pick == 2)
			it.run_length = 11'(units);
		else if (len_pick < 8)
			it.run_length = 11'($urandom_range(units, 1));
		else
			it.run_length = 11'($urandom_range(short_max, 1));
		return it;
	endfunction

	// Send one item, idling before it at random; record its result on acceptance
	task automatic send_request(input in_item_t it);
		@(negedge clk);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= it;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_results.push_back(allocator_predict(it));
	endtask

	// Drop valid and wait until every result has come back
	task automatic wait_for_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// Write the map size register while the block is idle
	task automatic write_map_size(input logic [7:0] value);
		wait_for_results();
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		map_size_cfg = value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Receiver: stall at random on each falling edge
	always @(negedge clk)
		out_stall <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);

	// Check each accepted result against the oldest prediction
	always @(posedge clk) begin : check_results
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result: status %0d start %0d bit %0d", $time,
					out_item.status, out_item.start_index, out_item.bit_read);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (out_item.status !== want.status) begin
					$display("%0t: status mismatch: expected %0d, actual %0d", $time,
						want.status, out_item.status);
					error_count++;
				end
				if (out_item.start_index !== want.start_index) begin
					$display("%0t: start_index mismatch: expected %0d, actual %0d", $time,
						want.start_index, out_item.start_index);
					error_count++;
				end
				if (out_item.bit_read !== want.bit_read) begin
					$display("%0t: bit_read mismatch: expected %0d, actual %0d", $time,
						want.bit_read, out_item.bit_read);
					error_count++;
				end
			end
		end
	end

	// Full map at reset size: bit ends, run lengths at and past the map size
	task automatic test_full_map();
		send_request(make_req(REQ_TEST, 0, 1'b0, 0));
		send_request(make_req(REQ_WRITE, 0, 1'b1, 0));
		send_request(make_req(REQ_TEST, 0, 1'b1, 0));
		send_request(make_req(REQ_WRITE, 1023, 1'b1, 0));
		send_request(make_req(REQ_TEST, 1023, 1'b0, 0));
		send_request(make_req(REQ_SCAN, 0, 1'b0, 1));
		send_request(make_req(REQ_SCAN, 0, 1'b0, 1023));
		send_request(make_req(REQ_SCAN, 0, 1'b0, 1024));
		send_request(make_req(REQ_SCAN, 0, 1'b0, 0));
		send_request(make_req(REQ_SCAN, 1023, 1'b1, 2047));
		send_request(make_req(REQ_WRITE, 1023, 1'b0, 0));
		send_request(make_req(REQ_SCAN, 0, 1'b0, 1023));
		send_request(make_req(REQ_CLEAR, 0, 1'b0, 0));
		send_request(make_req(REQ_SCAN, 0, 1'b0, 1024));
		send_request(make_req(REQ_WRITE, 1000, 1'b1, 0));
	endtask

	// Map size zero acts as one byte; clear touches only that byte
	task automatic test_min_map();
		write_map_size(8'd0);
		send_request(make_req(REQ_TEST, 8, 1'b0, 0));
		send_request(make_req(REQ_WRITE, 7, 1'b1, 0));
		send_request(make_req(REQ_WRITE, 8, 1'b1, 0));
		send_request(make_req(REQ_TEST, 7, 1'b0, 0));
		send_request(make_req(REQ_SCAN, 0, 1'b0, 8));
		send_request(make_req(REQ_SCAN, 0, 1'b0, 7));
		send_request(make_req(REQ_SCAN, 0, 1'b0, 9));
		send_request(make_req(REQ_CLEAR, 0, 1'b0, 0));
	endtask

	// Oversize map size clamps to the depth; bytes outside the last clear survive
	task automatic test_clamped_map();
		write_map_size(8'hff);
		send_request(make_req(REQ_TEST, 1000, 1'b0, 0));
		send_request(make_req(REQ_SCAN, 0, 1'b0, 1024));
	endtask

	// Random traffic over three map sizes under one idling pattern
	task automatic test_random_traffic(input int send_pct, input int recv_pct,
			input logic [7:0] size_a, input logic [7:0] size_b, input logic [7:0] size_c);
		logic [7:0] sizes [3];
		int         p;
		int         n;
		sizes[0] = size_a;
		sizes[1] = size_b;
		sizes[2] = size_c;
		for (p = 0; p < 3; p++) begin
			write_map_size(sizes[p]);
			send_idle_pct = send_pct;
			recv_idle_pct = recv_pct;
			for (n = 0; n < ITEMS_PER_PHASE; n++)
				send_request(random_req());
			wait_for_results();
			send_idle_pct = 0;
			recv_idle_pct = 0;
		end
	endtask

	initial begin
		arst_n      = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = 8'h00;
		in_valid    = 1'b0;
		in_item     = '0;
		out_stall   = 1'b0;
		map_size_cfg = MAP_BYTES_RST;
		foreach (unit_map[i])
			unit_map[i] = 8'h00;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		test_full_map();
		test_min_map();
		test_clamped_map();
		test_random_traffic(32, 51, 8'd128, 8'd1, 8'd37);
		test_random_traffic(51, 32, 8'd200, 8'd16, 8'd3);
		test_random_traffic(0, 0, 8'd8, 8'd64, 8'($urandom));

		// Drain and watch for stray results
		wait_for_results();
		repeat (MAP_DEPTH + 8) @(posedge clk);
		if (error_count == 0)
			$display("** bitmap_run_allocator_core: PASSED **");
		else
			$display("** bitmap_run_allocator_core: FAILED **");
		$finish;
	end

endmodule
